// ===== hdl/psw_pkg.sv =====
// Shared types and constants for the priority scheduler (wait and turnaround times).
// No dependencies; used by psw_dp, psw_ctrl and the top level.
`default_nettype none

package psw_pkg;

  localparam int MAX_JOBS_DEF = 32;
  localparam int BURST_W      = 16;
  localparam int RANK_W       = 8;
  localparam int ID_W         = 6;
  localparam int WAIT_W       = 21;
  localparam int AVG_W        = 29;
  localparam int FRAC_W       = 8;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [RANK_W-1:0]  rank;
  } entry_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_PREP,
    OP_RD_I,
    OP_CUR,
    OP_RD_J,
    OP_CMP,
    OP_WR_I,
    OP_RD_K,
    OP_SUM,
    OP_DIV_GO,
    OP_EMIT
  } dp_op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_RD_I,
    ST_CUR,
    ST_CMP,
    ST_RD_J,
    ST_WR_I,
    ST_SUM_RD,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_EMIT_RD,
    ST_EMIT
  } state_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    logic few_jobs;
    logic j_end;
    logic i_end;
    logic k_last;
    logic div_busy;
  } sts_t;

endpackage

`default_nettype wire

// ===== hdl/psw_div.sv =====
// Two-lane restoring divider, one quotient bit per cycle, shared divisor.
// Depends on nothing but its parameters.
`default_nettype none

module psw_div #(
  parameter int DVD_W  = 36,
  parameter int DVSR_W = 6
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [DVD_W-1:0]  dvd_a_i,
  input  wire logic [DVD_W-1:0]  dvd_b_i,
  input  wire logic [DVSR_W-1:0] dvsr_i,
  output logic                   busy_o,
  output logic [DVD_W-1:0]       quo_a_o,
  output logic [DVD_W-1:0]       quo_b_o
);

  localparam int STEP_W = $clog2(DVD_W + 1);

  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [DVSR_W-1:0] dvsr_q;
  logic [DVD_W-1:0]  quo_q [2];
  logic [DVD_W-1:0]  quo_d [2];
  logic [DVSR_W-1:0] rem_q [2];
  logic [DVSR_W-1:0] rem_d [2];

  // dividend bits shift out the top while quotient bits shift in the bottom
  always_comb begin
    logic [DVSR_W:0] trial;
    logic            ge;
    for (int l = 0; l < 2; l++) begin
      trial    = {rem_q[l], quo_q[l][DVD_W-1]};
      ge       = (trial >= {1'b0, dvsr_q});
      rem_d[l] = ge ? DVSR_W'(trial - {1'b0, dvsr_q}) : trial[DVSR_W-1:0];
      quo_d[l] = {quo_q[l][DVD_W-2:0], ge};
    end
    cnt_d = cnt_q - STEP_W'(1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (start_i) begin
      cnt_q <= STEP_W'(DVD_W);
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvsr_q   <= dvsr_i;
      quo_q[0] <= dvd_a_i;
      quo_q[1] <= dvd_b_i;
      rem_q[0] <= '0;
      rem_q[1] <= '0;
    end else if (cnt_q != '0) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign busy_o  = (cnt_q != '0);
  assign quo_a_o = quo_q[0];
  assign quo_b_o = quo_q[1];

endmodule

`default_nettype wire

// ===== hdl/psw_dp.sv =====
// Datapath: job memory, sort/scan indexes, prefix sums, divider and result registers.
// Depends on psw_pkg and psw_div.
`default_nettype none

module psw_dp #(
  parameter int MAX_JOBS = psw_pkg::MAX_JOBS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire psw_pkg::cmd_t                 cmd_i,
  output psw_pkg::sts_t                      sts_o,
  input  wire logic [psw_pkg::BURST_W-1:0]   burst_time_i,
  input  wire logic [psw_pkg::RANK_W-1:0]    job_priority_i,
  output logic                               result_strobe_o,
  output logic [psw_pkg::ID_W-1:0]           job_id_o,
  output logic [psw_pkg::BURST_W-1:0]        job_burst_o,
  output logic [psw_pkg::RANK_W-1:0]         job_rank_o,
  output logic [psw_pkg::WAIT_W-1:0]         wait_time_o,
  output logic [psw_pkg::WAIT_W-1:0]         turnaround_o,
  output logic [psw_pkg::AVG_W-1:0]          avg_wait_q8_o,
  output logic [psw_pkg::AVG_W-1:0]          avg_turnaround_q8_o,
  output logic                               overflowed_o,
  output logic                               last_result_o
);

  localparam int CNT_W = $clog2(MAX_JOBS + 1);
  localparam int IDX_W = $clog2(MAX_JOBS);
  localparam int ACC_W = (psw_pkg::BURST_W + CNT_W > psw_pkg::WAIT_W) ?
                         psw_pkg::BURST_W + CNT_W : psw_pkg::WAIT_W;
  localparam int TOT_W = ACC_W + CNT_W;
  localparam int DVD_W = TOT_W + psw_pkg::FRAC_W;

  psw_pkg::entry_t job_mem [MAX_JOBS];
  psw_pkg::entry_t rd_q;
  psw_pkg::entry_t cur_q, cur_d;
  psw_pkg::entry_t wdata;
  logic [IDX_W-1:0] waddr, raddr;
  logic             we;

  logic [CNT_W-1:0] count_q, count_d;
  logic             ovf_q, ovf_d;
  logic [IDX_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic [ACC_W-1:0] acc_q, acc_d, tat;
  logic [TOT_W-1:0] tot_wt_q, tot_wt_d, tot_tat_q, tot_tat_d;

  logic [psw_pkg::ID_W+CNT_W-1:0] id_full;
  logic                           room;

  logic             div_go, div_busy;
  logic [DVD_W-1:0] quo_wt, quo_tat;

  assign room    = (count_q < CNT_W'(MAX_JOBS));
  assign id_full = (psw_pkg::ID_W + CNT_W)'(count_q) + (psw_pkg::ID_W + CNT_W)'(1);
  assign tat     = acc_q + ACC_W'(rd_q.burst);
  assign div_go  = (cmd_i.op == psw_pkg::OP_DIV_GO);

  always_comb begin
    case (cmd_i.op)
      psw_pkg::OP_RD_I: raddr = i_q;
      psw_pkg::OP_CUR:  raddr = i_q + IDX_W'(1);
      psw_pkg::OP_RD_J: raddr = j_q;
      default:          raddr = k_q;
    endcase
  end

  always_comb begin
    count_d   = count_q;
    ovf_d     = ovf_q;
    i_d       = i_q;
    j_d       = j_q;
    k_d       = k_q;
    acc_d     = acc_q;
    tot_wt_d  = tot_wt_q;
    tot_tat_d = tot_tat_q;
    cur_d     = cur_q;
    we        = 1'b0;
    waddr     = count_q[IDX_W-1:0];
    wdata     = '{id: id_full[psw_pkg::ID_W-1:0], burst: burst_time_i, rank: job_priority_i};
    case (cmd_i.op)
      psw_pkg::OP_LOAD: begin
        if (room) begin
          we      = 1'b1;
          count_d = count_q + CNT_W'(1);
        end else begin
          ovf_d = 1'b1;
        end
      end
      psw_pkg::OP_PREP: begin
        i_d       = '0;
        k_d       = '0;
        acc_d     = '0;
        tot_wt_d  = '0;
        tot_tat_d = '0;
      end
      psw_pkg::OP_CUR: begin
        cur_d = rd_q;
        j_d   = i_q + IDX_W'(1);
      end
      psw_pkg::OP_CMP: begin
        // position i lives in cur_q until the inner pass ends
        if (cur_q.rank > rd_q.rank) begin
          we    = 1'b1;
          waddr = j_q;
          wdata = cur_q;
          cur_d = rd_q;
        end
        j_d = j_q + IDX_W'(1);
      end
      psw_pkg::OP_WR_I: begin
        we    = 1'b1;
        waddr = i_q;
        wdata = cur_q;
        i_d   = i_q + IDX_W'(1);
      end
      psw_pkg::OP_SUM: begin
        tot_wt_d  = tot_wt_q + TOT_W'(acc_q);
        tot_tat_d = tot_tat_q + TOT_W'(tat);
        acc_d     = tat;
        k_d       = k_q + IDX_W'(1);
      end
      psw_pkg::OP_DIV_GO: begin
        k_d   = '0;
        acc_d = '0;
      end
      psw_pkg::OP_EMIT: begin
        acc_d = tat;
        k_d   = k_q + IDX_W'(1);
        if (sts_o.k_last) begin
          count_d = '0;
          ovf_d   = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      job_mem[waddr] <= wdata;
    end
    rd_q <= job_mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q         <= '0;
      ovf_q           <= 1'b0;
      result_strobe_o <= 1'b0;
    end else begin
      count_q         <= count_d;
      ovf_q           <= ovf_d;
      result_strobe_o <= (cmd_i.op == psw_pkg::OP_EMIT);
    end
  end

  always_ff @(posedge clk_i) begin
    i_q       <= i_d;
    j_q       <= j_d;
    k_q       <= k_d;
    acc_q     <= acc_d;
    tot_wt_q  <= tot_wt_d;
    tot_tat_q <= tot_tat_d;
    cur_q     <= cur_d;
    if (cmd_i.op == psw_pkg::OP_EMIT) begin
      job_id_o            <= rd_q.id;
      job_burst_o         <= rd_q.burst;
      job_rank_o          <= rd_q.rank;
      wait_time_o         <= acc_q[psw_pkg::WAIT_W-1:0];
      turnaround_o        <= tat[psw_pkg::WAIT_W-1:0];
      avg_wait_q8_o       <= sts_o.k_last ? quo_wt[psw_pkg::AVG_W-1:0] : '0;
      avg_turnaround_q8_o <= sts_o.k_last ? quo_tat[psw_pkg::AVG_W-1:0] : '0;
      overflowed_o        <= ovf_q;
      last_result_o       <= sts_o.k_last;
    end
  end

  psw_div #(
    .DVD_W  (DVD_W),
    .DVSR_W (CNT_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_go),
    .dvd_a_i ({tot_wt_q, psw_pkg::FRAC_W'(0)}),
    .dvd_b_i ({tot_tat_q, psw_pkg::FRAC_W'(0)}),
    .dvsr_i  (count_q),
    .busy_o  (div_busy),
    .quo_a_o (quo_wt),
    .quo_b_o (quo_tat)
  );

  always_comb begin
    sts_o.few_jobs = (count_q < CNT_W'(2));
    sts_o.j_end    = ((CNT_W'(j_q) + CNT_W'(1)) == count_q);
    sts_o.i_end    = (((CNT_W+1)'(i_q) + (CNT_W+1)'(2)) >= {1'b0, count_q});
    sts_o.k_last   = ((CNT_W'(k_q) + CNT_W'(1)) == count_q);
    sts_o.div_busy = div_busy;
  end

endmodule

`default_nettype wire

// ===== hdl/psw_ctrl.sv =====
// Controller: sequences load, exchange sort, prefix-sum scan, division and result emission.
// Depends on psw_pkg.
`default_nettype none

module psw_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic          last_item_i,
  input  wire psw_pkg::sts_t sts_i,
  output psw_pkg::cmd_t      cmd_o,
  output logic               busy_o
);

  psw_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= psw_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = psw_pkg::OP_NONE;
    busy_o    = 1'b1;
    case (state_q)
      psw_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.op = psw_pkg::OP_LOAD;
          if (last_item_i) begin
            state_d = psw_pkg::ST_PREP;
          end
        end
      end
      psw_pkg::ST_PREP: begin
        cmd_o.op = psw_pkg::OP_PREP;
        state_d  = sts_i.few_jobs ? psw_pkg::ST_SUM_RD : psw_pkg::ST_RD_I;
      end
      psw_pkg::ST_RD_I: begin
        cmd_o.op = psw_pkg::OP_RD_I;
        state_d  = psw_pkg::ST_CUR;
      end
      psw_pkg::ST_CUR: begin
        cmd_o.op = psw_pkg::OP_CUR;
        state_d  = psw_pkg::ST_CMP;
      end
      psw_pkg::ST_CMP: begin
        cmd_o.op = psw_pkg::OP_CMP;
        state_d  = sts_i.j_end ? psw_pkg::ST_WR_I : psw_pkg::ST_RD_J;
      end
      psw_pkg::ST_RD_J: begin
        cmd_o.op = psw_pkg::OP_RD_J;
        state_d  = psw_pkg::ST_CMP;
      end
      psw_pkg::ST_WR_I: begin
        cmd_o.op = psw_pkg::OP_WR_I;
        state_d  = sts_i.i_end ? psw_pkg::ST_SUM_RD : psw_pkg::ST_RD_I;
      end
      psw_pkg::ST_SUM_RD: begin
        cmd_o.op = psw_pkg::OP_RD_K;
        state_d  = psw_pkg::ST_SUM;
      end
      psw_pkg::ST_SUM: begin
        cmd_o.op = psw_pkg::OP_SUM;
        state_d  = sts_i.k_last ? psw_pkg::ST_DIV_GO : psw_pkg::ST_SUM_RD;
      end
      psw_pkg::ST_DIV_GO: begin
        cmd_o.op = psw_pkg::OP_DIV_GO;
        state_d  = psw_pkg::ST_DIV_WAIT;
      end
      psw_pkg::ST_DIV_WAIT: begin
        if (!sts_i.div_busy) begin
          state_d = psw_pkg::ST_EMIT_RD;
        end
      end
      psw_pkg::ST_EMIT_RD: begin
        cmd_o.op = psw_pkg::OP_RD_K;
        state_d  = psw_pkg::ST_EMIT;
      end
      psw_pkg::ST_EMIT: begin
        cmd_o.op = psw_pkg::OP_EMIT;
        state_d  = sts_i.k_last ? psw_pkg::ST_IDLE : psw_pkg::ST_EMIT_RD;
      end
      default: begin
        state_d = psw_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/priority_schedule_wait_times.sv =====
// Top level of the non-preemptive priority scheduler: controller plus datapath.
// Depends on psw_pkg, psw_ctrl, psw_dp (which holds psw_div).
//
// Jobs are requested one per cycle while busy is low; each job is stored in a
// single-port-write job memory of MAX_JOBS entries, extras are dropped and
// flagged. The request with last_item_i set starts the schedule and raises busy.
// The exchange sort reads and then compares each pair over one memory read port,
// then come a prefix-sum scan, a divider of one quotient bit per cycle, and an
// emission pass that reads each job before it puts out its result, each result
// valid for one cycle under result_strobe_o. The receiver cannot stall, so the
// results must be taken as they come.
`default_nettype none

module priority_schedule_wait_times #(
  parameter int MAX_JOBS = psw_pkg::MAX_JOBS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic [psw_pkg::BURST_W-1:0]   burst_time_i,
  input  wire logic [psw_pkg::RANK_W-1:0]    job_priority_i,
  input  wire logic                          last_item_i,
  output logic                               result_strobe_o,
  output logic [psw_pkg::ID_W-1:0]           job_id_o,
  output logic [psw_pkg::BURST_W-1:0]        job_burst_o,
  output logic [psw_pkg::RANK_W-1:0]         job_rank_o,
  output logic [psw_pkg::WAIT_W-1:0]         wait_time_o,
  output logic [psw_pkg::WAIT_W-1:0]         turnaround_o,
  output logic [psw_pkg::AVG_W-1:0]          avg_wait_q8_o,
  output logic [psw_pkg::AVG_W-1:0]          avg_turnaround_q8_o,
  output logic                               overflowed_o,
  output logic                               last_result_o
);

  psw_pkg::cmd_t cmd;
  psw_pkg::sts_t sts;

  psw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .last_item_i (last_item_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  psw_dp #(
    .MAX_JOBS (MAX_JOBS)
  ) u_dp (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cmd_i               (cmd),
    .sts_o               (sts),
    .burst_time_i        (burst_time_i),
    .job_priority_i      (job_priority_i),
    .result_strobe_o     (result_strobe_o),
    .job_id_o            (job_id_o),
    .job_burst_o         (job_burst_o),
    .job_rank_o          (job_rank_o),
    .wait_time_o         (wait_time_o),
    .turnaround_o        (turnaround_o),
    .avg_wait_q8_o       (avg_wait_q8_o),
    .avg_turnaround_q8_o (avg_turnaround_q8_o),
    .overflowed_o        (overflowed_o),
    .last_result_o       (last_result_o)
  );

  // a result only follows an emit step of a running schedule
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o |-> $past(busy))
    else $error("result strobe without a running schedule");

  // averages are shown only on the closing result
  a_avg_only_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && !last_result_o) |->
      (avg_wait_q8_o == '0 && avg_turnaround_q8_o == '0))
    else $error("average shown on a non-final result");

  // turnaround never falls below the waiting time in range
  a_tat_ge_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && MAX_JOBS <= psw_pkg::MAX_JOBS_DEF) |-> (turnaround_o >= wait_time_o))
    else $error("turnaround below waiting time");

  // the final result hands the block back to idle
  a_idle_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_strobe_o && last_result_o) |-> !busy || $past(start))
    else $error("block still busy after final result");

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for priority_schedule_wait_times: directed table, then random batches.
// Depends on psw_pkg and the RTL top level; the schedule is recomputed here and every result
// strobe is compared field by field against it.
`default_nettype none

module testbench;
  import psw_pkg::*;

  localparam int JOBS      = MAX_JOBS_DEF;
  localparam int RAND_JOBS = 100;
  localparam int LIMIT     = 200000;
  localparam int ROWS      = 17;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [BURST_W-1:0] burst;
    logic [RANK_W-1:0]  rank;
    logic [WAIT_W-1:0]  wait_ticks;
    logic [WAIT_W-1:0]  tat;
    logic [AVG_W-1:0]   avg_wait;
    logic [AVG_W-1:0]   avg_tat;
    logic               ovf;
    logic               fin;
  } sched_res_t;

  typedef struct packed {
    logic [BURST_W-1:0] burst;
    logic [RANK_W-1:0]  prio;
    logic               last;
    logic [5:0]         reps;
    logic               typed;
    sched_res_t         res;
  } stim_row_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start = 1'b0;
  logic                busy;
  logic [BURST_W-1:0]  burst_time = '0;
  logic [RANK_W-1:0]   job_priority = '0;
  logic                last_item = 1'b0;
  logic                result_strobe;
  logic [ID_W-1:0]     job_id;
  logic [BURST_W-1:0]  job_burst;
  logic [RANK_W-1:0]   job_rank;
  logic [WAIT_W-1:0]   wait_time;
  logic [WAIT_W-1:0]   turnaround;
  logic [AVG_W-1:0]    avg_wait_q8;
  logic [AVG_W-1:0]    avg_turnaround_q8;
  logic                overflowed;
  logic                last_result;

  // scheduler mirror
  entry_t      job_mem [JOBS];
  int unsigned job_cnt = 0;
  logic        drop_seen = 1'b0;
  sched_res_t  schedule_due [$];

  int unsigned errors = 0;
  int unsigned cycles = 0;
  int unsigned jobs_sent = 0;
  int unsigned burst_left = 0;
  logic        quiet_phase = 1'b0;

  // The single-job batches of this table carry their result typed in; the rest go through the mirror.
  stim_row_t dir_tab [ROWS] = '{
    '{16'd0,     8'd0,   1'b1, 6'd1, 1'b1,
      '{6'd1, 16'd0, 8'd0, 21'd0, 21'd0, 29'd0, 29'd0, 1'b0, 1'b1}},
    '{16'hFFFF,  8'hFF,  1'b1, 6'd1, 1'b1,
      '{6'd1, 16'hFFFF, 8'hFF, 21'd0, 21'd65535, 29'd0, 29'd16776960, 1'b0, 1'b1}},
    // mixed ranks with a tie
    '{16'd100,   8'd5,   1'b0, 6'd1, 1'b0, '0},
    '{16'd200,   8'd2,   1'b0, 6'd1, 1'b0, '0},
    '{16'd300,   8'd5,   1'b0, 6'd1, 1'b0, '0},
    '{16'd400,   8'd0,   1'b1, 6'd1, 1'b0, '0},
    // all equal: strict compare never swaps
    '{16'd7,     8'd9,   1'b0, 6'd1, 1'b0, '0},
    '{16'd11,    8'd9,   1'b0, 6'd1, 1'b0, '0},
    '{16'd13,    8'd9,   1'b1, 6'd1, 1'b0, '0},
    // reversed ranks
    '{16'd1,     8'd255, 1'b0, 6'd1, 1'b0, '0},
    '{16'd2,     8'd128, 1'b0, 6'd1, 1'b0, '0},
    '{16'd3,     8'd1,   1'b0, 6'd1, 1'b0, '0},
    '{16'd4,     8'd0,   1'b1, 6'd1, 1'b0, '0},
    '{16'h8000,  8'h80,  1'b0, 6'd1, 1'b0, '0},
    '{16'h7FFF,  8'h7F,  1'b1, 6'd1, 1'b0, '0},
    // full batch of max bursts, then a marked job that is dropped but still ends the batch
    '{16'hFFFF,  8'hFF,  1'b0, 6'd32, 1'b0, '0},
    '{16'h0001,  8'h00,  1'b1, 6'd1, 1'b0, '0}
  };

  priority_schedule_wait_times u_dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .start               (start),
    .busy                (busy),
    .burst_time_i        (burst_time),
    .job_priority_i      (job_priority),
    .last_item_i         (last_item),
    .result_strobe_o     (result_strobe),
    .job_id_o            (job_id),
    .job_burst_o         (job_burst),
    .job_rank_o          (job_rank),
    .wait_time_o         (wait_time),
    .turnaround_o        (turnaround),
    .avg_wait_q8_o       (avg_wait_q8),
    .avg_turnaround_q8_o (avg_turnaround_q8),
    .overflowed_o        (overflowed),
    .last_result_o       (last_result)
  );

  always #6 clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("[%0d] MISMATCH: %s", cycles, msg);
    errors++;
  endtask

  task automatic check_field(input string name, input logic [AVG_W-1:0] got,
                             input logic [AVG_W-1:0] want);
    if (got !== want)
      report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
  endtask

  // Store one job; on the batch end, order the jobs and queue the schedule.
  task automatic predict_schedule(input logic [BURST_W-1:0] b, input logic [RANK_W-1:0] p,
                                  input logic l);
    entry_t      tmp;
    sched_res_t  r;
    logic [63:0] run, tot_w, tot_t;
    int unsigned n;
    if (job_cnt < JOBS) begin
      job_mem[job_cnt] = '{id: ID_W'(job_cnt + 1), burst: b, rank: p};
      job_cnt++;
    end else begin
      drop_seen = 1'b1;
    end
    if (!l) return;
    n = job_cnt;
    for (int i = 0; i + 1 < n; i++) begin
      for (int j = i + 1; j < n; j++) begin
        if (job_mem[i].rank > job_mem[j].rank) begin
          tmp = job_mem[i];
          job_mem[i] = job_mem[j];
          job_mem[j] = tmp;
        end
      end
    end
    run = 0;
    tot_w = 0;
    tot_t = 0;
    for (int k = 0; k < n; k++) begin
      tot_w += run;
      tot_t += run + job_mem[k].burst;
      run += job_mem[k].burst;
    end
    run = 0;
    for (int k = 0; k < n; k++) begin
      r.id         = job_mem[k].id;
      r.burst      = job_mem[k].burst;
      r.rank       = job_mem[k].rank;
      r.wait_ticks = WAIT_W'(run);
      r.tat        = WAIT_W'(run + job_mem[k].burst);
      r.fin        = (k + 1 == n);
      r.avg_wait   = r.fin ? AVG_W'((tot_w << FRAC_W) / n) : '0;
      r.avg_tat    = r.fin ? AVG_W'((tot_t << FRAC_W) / n) : '0;
      r.ovf        = drop_seen;
      schedule_due.push_back(r);
      run += job_mem[k].burst;
    end
    job_cnt = 0;
    drop_seen = 1'b0;
  endtask

  // Hold one request until taken, then apply the sender's burst/gap pattern.
  task automatic send_job(input logic [BURST_W-1:0] b, input logic [RANK_W-1:0] p,
                          input logic l, input logic use_typed = 1'b0,
                          input sched_res_t typed_res = '0);
    int unsigned gap;
    start        <= 1'b1;
    burst_time   <= b;
    job_priority <= p;
    last_item    <= l;
    do @(posedge clk_i); while (busy);
    predict_schedule(b, p, l);
    if (use_typed) begin
      void'(schedule_due.pop_back());
      schedule_due.push_back(typed_res);
    end
    jobs_sent++;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = quiet_phase ? 0 : $urandom_range(0, 5);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end else begin
      burst_left--;
    end
  endtask

  task automatic hold_until_drained();
    start <= 1'b0;
    while (schedule_due.size() != 0) @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin : result_check
    sched_res_t want;
    if (rst_ni && result_strobe) begin
      if (schedule_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result, job_id %0d", job_id));
      end else begin
        want = schedule_due.pop_front();
        check_field("job_id", AVG_W'(job_id), AVG_W'(want.id));
        check_field("job_burst", AVG_W'(job_burst), AVG_W'(want.burst));
        check_field("job_rank", AVG_W'(job_rank), AVG_W'(want.rank));
        check_field("wait_time", AVG_W'(wait_time), AVG_W'(want.wait_ticks));
        check_field("turnaround", AVG_W'(turnaround), AVG_W'(want.tat));
        check_field("avg_wait_q8", avg_wait_q8, want.avg_wait);
        check_field("avg_turnaround_q8", avg_turnaround_q8, want.avg_tat);
        check_field("overflowed", AVG_W'(overflowed), AVG_W'(want.ovf));
        check_field("last_result", AVG_W'(last_result), AVG_W'(want.fin));
      end
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("priority_schedule_wait_times verification failed");
      $finish;
    end
  end

  initial begin
    int unsigned        n;
    logic               tie_heavy;
    logic [BURST_W-1:0] b;
    logic [RANK_W-1:0]  p;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[i]) begin
      for (int r = 0; r < dir_tab[i].reps; r++)
        send_job(dir_tab[i].burst, dir_tab[i].prio,
                 dir_tab[i].last && (r + 1 == dir_tab[i].reps),
                 dir_tab[i].typed, dir_tab[i].res);
    end
    hold_until_drained();

    jobs_sent = 0;
    while (jobs_sent < RAND_JOBS) begin
      // mostly short batches; now and then one near or past capacity
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(JOBS - 2, JOBS + 3)
                                      : $urandom_range(1, 8);
      tie_heavy   = ($urandom_range(0, 2) == 0);
      quiet_phase = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < n; k++) begin
        case ($urandom_range(0, 5))
          0:       b = '0;
          1:       b = '1;
          default: b = BURST_W'($urandom);
        endcase
        p = tie_heavy ? RANK_W'($urandom_range(0, 3)) : RANK_W'($urandom_range(0, 255));
        send_job(b, p, k + 1 == n);
      end
      if ($urandom_range(0, 5) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("priority_schedule_wait_times verification clean");
    end else begin
      $display("priority_schedule_wait_times verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
